[hw/rtl/rbqp_pkg.sv]
// Package for the read base quality profiler: sizes, state encoding and the
// command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package rbqp_pkg;

   localparam int MAX_READ_LEN = 512;
   localparam int QUAL_BINS    = 128;
   localparam int GC_BINS      = 101;
   localparam int POS_ENTRIES  = MAX_READ_LEN * 8;
   localparam int POS_AW       = $clog2(POS_ENTRIES);
   localparam int LEN_AW       = $clog2(MAX_READ_LEN);
   localparam int QUAL_AW      = $clog2(QUAL_BINS);
   localparam int GC_AW        = $clog2(GC_BINS);
   localparam int CLR_W        = POS_AW + 1;
   localparam int DIV_STEPS    = 24;
   localparam int DIV_CW       = $clog2(DIV_STEPS);

   localparam logic [7:0]  QOFS_33   = 8'd33;
   localparam logic [7:0]  QOFS_64   = 8'd64;
   localparam logic [7:0]  Q20       = 8'd20;
   localparam logic [7:0]  Q30       = 8'd30;
   localparam logic [15:0] LEN_MAX   = 16'hFFFF;
   localparam logic [23:0] QSUM_MAX  = 24'hFFFFFF;
   localparam logic [23:0] PCT_SCALE = 24'd100;

   localparam logic ACT_BASE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_STAT    = 1'b1;

   localparam logic [2:0] TSEL_POS_COUNT = 3'd0;
   localparam logic [2:0] TSEL_POS_QSUM  = 3'd1;
   localparam logic [2:0] TSEL_LENGTH    = 3'd2;
   localparam logic [2:0] TSEL_GC        = 3'd3;
   localparam logic [2:0] TSEL_QUAL      = 3'd4;
   localparam logic [2:0] TSEL_TOTALS    = 3'd5;

   localparam logic [11:0] TOT_Q20     = 12'd0;
   localparam logic [11:0] TOT_Q30     = 12'd1;
   localparam logic [11:0] TOT_BASES   = 12'd2;
   localparam logic [11:0] TOT_GC      = 12'd3;
   localparam logic [11:0] TOT_LONGEST = 12'd4;
   localparam logic [11:0] TOT_READS   = 12'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS_RD,
      ST_POS_WR,
      ST_DIV_LOAD,
      ST_DIV,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_LOOK_RD,
      ST_LOOK_CAP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_wr;
      logic pos_wr;
      logic div_load;
      logic div_step;
      logic hist_wr;
      logic look_cap;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic action;
      logic last;
      logic clr_done;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/rbqp_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbqp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rbqp_ctrl.sv]
// Controller state machine of the profiler: sequences clear, base update,
// division, histogram update, lookup and result hand-off. Uses rbqp_pkg.
`timescale 1ns / 1ps

module rbqp_ctrl import rbqp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_POS_RD;
            end
         end
         ST_POS_RD: begin
            // item now captured; branch on its kind
            if (status.action == ACT_READ) begin
               state_in = ST_LOOK_CAP;
            end else begin
               state_in = ST_POS_WR;
            end
         end
         ST_POS_WR: begin
            cmd.pos_wr = 1'b1;
            state_in   = status.last ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_HIST_RD;
            end
         end
         ST_HIST_RD: begin
            state_in = ST_HIST_WR;
         end
         ST_HIST_WR: begin
            cmd.hist_wr = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_LOOK_RD: begin
            state_in = ST_LOOK_CAP;
         end
         ST_LOOK_CAP: begin
            cmd.look_cap = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/rbqp_dp.sv]
// Datapath of the profiler: item capture, totals, per-read sums, shared
// restoring dividers, the five statistic RAMs and the result register.
// Uses rbqp_pkg and rbqp_ram.
`timescale 1ns / 1ps

module rbqp_dp import rbqp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   input  logic          req_action,
   input  logic [7:0]    req_base_char,
   input  logic [7:0]    req_quality_char,
   input  logic          req_last_of_read,
   input  logic [2:0]    req_table_select,
   input  logic [11:0]   req_entry_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_result_kind,
   output logic [15:0]   rsp_read_length,
   output logic [6:0]    rsp_gc_percent_bin,
   output logic [6:0]    rsp_mean_quality_bin,
   output logic          rsp_position_overflow,
   output logic [63:0]   rsp_stat_value,
   output logic          rsp_index_valid
);

   logic phred_ff;
   logic [CLR_W-1:0] clr_cnt_ff;

   logic        act_ff, last_ff;
   logic [2:0]  base_ff, tsel_ff;
   logic [7:0]  qchar_ff;
   logic [11:0] idx_ff;

   logic [63:0] q20_ff, q30_ff, bases_ff, gc_tot_ff, reads_ff;
   logic [15:0] longest_ff, cur_pos_ff, cur_gc_ff;
   logic [23:0] cur_qsum_ff;
   logic        cur_ovf_ff;

   logic [15:0]       den_ff;
   logic [23:0]       num_gc_ff, num_q_ff;
   logic [16:0]       rem_gc_ff, rem_q_ff;
   logic [DIV_CW-1:0] div_cnt_ff;
   logic              ovf_hold_ff;

   logic [63:0] stat_hold_ff;
   logic        valid_hold_ff;

   logic        out_valid_ff, kind_ff, ovf_out_ff, ivalid_out_ff;
   logic [15:0] len_out_ff;
   logic [6:0]  gc_out_ff, mq_out_ff;
   logic [63:0] stat_out_ff;

   logic [7:0]  qoff, qval;
   logic        is_gc, pos_in_range;
   logic [24:0] qsum_wide;
   logic [16:0] rem_gc_sh, rem_q_sh;
   logic        gc_ge, q_ge;
   logic [15:0] len_clamp;
   logic [LEN_AW-1:0]  len_bin;
   logic [GC_AW-1:0]   gc_bin;
   logic [QUAL_AW-1:0] qual_bin;
   logic [6:0]         mq_sat;

   logic [POS_AW-1:0]  pos_addr;
   logic [LEN_AW-1:0]  len_addr;
   logic [GC_AW-1:0]   gc_addr;
   logic [QUAL_AW-1:0] ql_addr;
   logic pos_we, len_we, gc_we, ql_we;
   logic [63:0] cnt_rd, qs_rd, len_rd, gc_rd, ql_rd;
   logic [63:0] cnt_wd, qs_wd, len_wd, gc_wd, ql_wd;
   logic [63:0] look_val;
   logic        look_ok;

   assign qoff  = phred_ff ? QOFS_64 : QOFS_33;
   assign qval  = (qchar_ff > qoff) ? qchar_ff - qoff : 8'd0;
   assign is_gc = (base_ff[1:0] == 2'd3);
   assign pos_in_range = cur_pos_ff < 16'(MAX_READ_LEN);
   assign qsum_wide = {1'b0, cur_qsum_ff} + {17'd0, qval};

   // one restoring step for both quotients
   assign rem_gc_sh = {rem_gc_ff[15:0], num_gc_ff[23]};
   assign rem_q_sh  = {rem_q_ff[15:0], num_q_ff[23]};
   assign gc_ge     = rem_gc_sh >= {1'b0, den_ff};
   assign q_ge      = rem_q_sh >= {1'b0, den_ff};

   assign len_clamp = (den_ff > 16'(MAX_READ_LEN)) ? 16'(MAX_READ_LEN) : den_ff;
   assign len_bin   = LEN_AW'(len_clamp - 16'd1);
   assign gc_bin    = (num_gc_ff > 24'(GC_BINS - 1)) ? GC_AW'(GC_BINS - 1)
                                                     : num_gc_ff[GC_AW-1:0];
   assign qual_bin  = (num_q_ff > 24'(QUAL_BINS - 1)) ? QUAL_AW'(QUAL_BINS - 1)
                                                      : num_q_ff[QUAL_AW-1:0];
   assign mq_sat    = (num_q_ff > 24'd127) ? 7'd127 : num_q_ff[6:0];

   assign pos_addr = cmd.clear_wr ? clr_cnt_ff[POS_AW-1:0] :
                     act_ff ? idx_ff[POS_AW-1:0] : {cur_pos_ff[POS_AW-4:0], base_ff};
   assign len_addr = cmd.clear_wr ? clr_cnt_ff[LEN_AW-1:0] :
                     act_ff ? idx_ff[LEN_AW-1:0] : len_bin;
   assign gc_addr  = cmd.clear_wr ? clr_cnt_ff[GC_AW-1:0] :
                     act_ff ? idx_ff[GC_AW-1:0] : gc_bin;
   assign ql_addr  = cmd.clear_wr ? clr_cnt_ff[QUAL_AW-1:0] :
                     act_ff ? idx_ff[QUAL_AW-1:0] : qual_bin;

   assign pos_we = cmd.clear_wr | (cmd.pos_wr & pos_in_range);
   assign len_we = (cmd.clear_wr & (clr_cnt_ff < CLR_W'(MAX_READ_LEN))) | cmd.hist_wr;
   assign gc_we  = (cmd.clear_wr & (clr_cnt_ff < CLR_W'(GC_BINS))) | cmd.hist_wr;
   assign ql_we  = (cmd.clear_wr & (clr_cnt_ff < CLR_W'(QUAL_BINS))) | cmd.hist_wr;

   assign cnt_wd = cmd.clear_wr ? 64'd0 : cnt_rd + 64'd1;
   assign qs_wd  = cmd.clear_wr ? 64'd0 : qs_rd + {56'd0, qval};
   assign len_wd = cmd.clear_wr ? 64'd0 : len_rd + 64'd1;
   assign gc_wd  = cmd.clear_wr ? 64'd0 : gc_rd + 64'd1;
   assign ql_wd  = cmd.clear_wr ? 64'd0 : ql_rd + 64'd1;

   rbqp_ram #(.WIDTH(64), .DEPTH(POS_ENTRIES)) u_pos_cnt (
      .clock(clock), .wr_en(pos_we), .addr(pos_addr), .wr_data(cnt_wd), .rd_data(cnt_rd));
   rbqp_ram #(.WIDTH(64), .DEPTH(POS_ENTRIES)) u_pos_qsum (
      .clock(clock), .wr_en(pos_we), .addr(pos_addr), .wr_data(qs_wd), .rd_data(qs_rd));
   rbqp_ram #(.WIDTH(64), .DEPTH(MAX_READ_LEN)) u_len_hist (
      .clock(clock), .wr_en(len_we), .addr(len_addr), .wr_data(len_wd), .rd_data(len_rd));
   rbqp_ram #(.WIDTH(64), .DEPTH(GC_BINS)) u_gc_hist (
      .clock(clock), .wr_en(gc_we), .addr(gc_addr), .wr_data(gc_wd), .rd_data(gc_rd));
   rbqp_ram #(.WIDTH(64), .DEPTH(QUAL_BINS)) u_qual_hist (
      .clock(clock), .wr_en(ql_we), .addr(ql_addr), .wr_data(ql_wd), .rd_data(ql_rd));

   always_comb begin
      look_val = 64'd0;
      look_ok  = 1'b0;
      unique case (tsel_ff)
         TSEL_POS_COUNT: begin
            look_ok  = {1'b0, idx_ff} < 13'(POS_ENTRIES);
            look_val = cnt_rd;
         end
         TSEL_POS_QSUM: begin
            look_ok  = {1'b0, idx_ff} < 13'(POS_ENTRIES);
            look_val = qs_rd;
         end
         TSEL_LENGTH: begin
            look_ok  = idx_ff < 12'(MAX_READ_LEN);
            look_val = len_rd;
         end
         TSEL_GC: begin
            look_ok  = idx_ff < 12'(GC_BINS);
            look_val = gc_rd;
         end
         TSEL_QUAL: begin
            look_ok  = idx_ff < 12'(QUAL_BINS);
            look_val = ql_rd;
         end
         TSEL_TOTALS: begin
            look_ok = 1'b1;
            unique case (idx_ff)
               TOT_Q20:     look_val = q20_ff;
               TOT_Q30:     look_val = q30_ff;
               TOT_BASES:   look_val = bases_ff;
               TOT_GC:      look_val = gc_tot_ff;
               TOT_LONGEST: look_val = {48'd0, longest_ff};
               TOT_READS:   look_val = reads_ff;
               default:     look_ok  = 1'b0;
            endcase
         end
         default: begin
            look_ok = 1'b0;
         end
      endcase
      if (!look_ok) begin
         look_val = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phred_ff     <= 1'b0;
         clr_cnt_ff   <= '0;
         q20_ff       <= '0;
         q30_ff       <= '0;
         bases_ff     <= '0;
         gc_tot_ff    <= '0;
         reads_ff     <= '0;
         longest_ff   <= '0;
         cur_pos_ff   <= '0;
         cur_gc_ff    <= '0;
         cur_qsum_ff  <= '0;
         cur_ovf_ff   <= 1'b0;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phred_ff <= csr_wr_data;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
         end
         if (cmd.pos_wr) begin
            if (qval >= Q20) q20_ff <= q20_ff + 64'd1;
            if (qval >= Q30) q30_ff <= q30_ff + 64'd1;
            bases_ff <= bases_ff + 64'd1;
            if (is_gc) begin
               gc_tot_ff <= gc_tot_ff + 64'd1;
               if (cur_gc_ff < LEN_MAX) cur_gc_ff <= cur_gc_ff + 16'd1;
            end
            cur_qsum_ff <= (qsum_wide > {1'b0, QSUM_MAX}) ? QSUM_MAX : qsum_wide[23:0];
            if (!pos_in_range) cur_ovf_ff <= 1'b1;
            if (cur_pos_ff < LEN_MAX) cur_pos_ff <= cur_pos_ff + 16'd1;
         end
         if (cmd.div_load) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CW'(1);
         end
         if (cmd.hist_wr) begin
            reads_ff <= reads_ff + 64'd1;
            if (den_ff > longest_ff) longest_ff <= den_ff;
            cur_pos_ff  <= '0;
            cur_gc_ff   <= '0;
            cur_qsum_ff <= '0;
            cur_ovf_ff  <= 1'b0;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         last_ff  <= req_last_of_read;
         base_ff  <= req_base_char[2:0];
         qchar_ff <= req_quality_char;
         tsel_ff  <= req_table_select;
         idx_ff   <= req_entry_index;
      end
      if (cmd.div_load) begin
         den_ff      <= cur_pos_ff;
         num_gc_ff   <= {8'd0, cur_gc_ff} * PCT_SCALE;
         num_q_ff    <= cur_qsum_ff;
         rem_gc_ff   <= '0;
         rem_q_ff    <= '0;
         ovf_hold_ff <= cur_ovf_ff;
      end else if (cmd.div_step) begin
         rem_gc_ff <= gc_ge ? rem_gc_sh - {1'b0, den_ff} : rem_gc_sh;
         rem_q_ff  <= q_ge ? rem_q_sh - {1'b0, den_ff} : rem_q_sh;
         num_gc_ff <= {num_gc_ff[22:0], gc_ge};
         num_q_ff  <= {num_q_ff[22:0], q_ge};
      end
      if (cmd.look_cap) begin
         stat_hold_ff  <= look_val;
         valid_hold_ff <= look_ok;
      end
      if (cmd.emit) begin
         kind_ff <= act_ff ? KIND_STAT : KIND_SUMMARY;
         if (act_ff) begin
            len_out_ff    <= '0;
            gc_out_ff     <= '0;
            mq_out_ff     <= '0;
            ovf_out_ff    <= 1'b0;
            stat_out_ff   <= stat_hold_ff;
            ivalid_out_ff <= valid_hold_ff;
         end else begin
            len_out_ff    <= den_ff;
            gc_out_ff     <= 7'(gc_bin);
            mq_out_ff     <= mq_sat;
            ovf_out_ff    <= ovf_hold_ff;
            stat_out_ff   <= '0;
            ivalid_out_ff <= 1'b0;
         end
      end
   end

   assign status.action   = act_ff;
   assign status.last     = last_ff;
   assign status.clr_done = clr_cnt_ff == CLR_W'(POS_ENTRIES - 1);
   assign status.div_done = div_cnt_ff == DIV_CW'(DIV_STEPS - 1);
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid             = out_valid_ff;
   assign rsp_result_kind       = kind_ff;
   assign rsp_read_length       = len_out_ff;
   assign rsp_gc_percent_bin    = gc_out_ff;
   assign rsp_mean_quality_bin  = mq_out_ff;
   assign rsp_position_overflow = ovf_out_ff;
   assign rsp_stat_value        = stat_out_ff;
   assign rsp_index_valid       = ivalid_out_ff;

endmodule

[hw/rtl/read_base_quality_profiler_top.sv]
// A base that does not end a read is captured and added to the position RAMs; a
// read-ending base then also runs the shared restoring dividers and the histogram
// update before its summary. One transaction is in the block at a time.
// Reset: synchronous; afterwards a clearing pass zeroes every statistic RAM while
// req_stall stays high. Configuration writes are taken whenever reset is low.
`timescale 1ns / 1ps

module read_base_quality_profiler_top import rbqp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_base_char,
   input  logic [7:0]  req_quality_char,
   input  logic        req_last_of_read,
   input  logic [2:0]  req_table_select,
   input  logic [11:0] req_entry_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_read_length,
   output logic [6:0]  rsp_gc_percent_bin,
   output logic [6:0]  rsp_mean_quality_bin,
   output logic        rsp_position_overflow,
   output logic [63:0] rsp_stat_value,
   output logic        rsp_index_valid
);

   // The controller only sequences; all storage and arithmetic live in the
   // datapath. The response register parts the two channels, so a new
   // transaction is accepted while a finished result still waits.
   dp_cmd_type    cmd;
   dp_status_type status;

   rbqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbqp_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_action            (req_action),
      .req_base_char         (req_base_char),
      .req_quality_char      (req_quality_char),
      .req_last_of_read      (req_last_of_read),
      .req_table_select      (req_table_select),
      .req_entry_index       (req_entry_index),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_read_length       (rsp_read_length),
      .rsp_gc_percent_bin    (rsp_gc_percent_bin),
      .rsp_mean_quality_bin  (rsp_mean_quality_bin),
      .rsp_position_overflow (rsp_position_overflow),
      .rsp_stat_value        (rsp_stat_value),
      .rsp_index_valid       (rsp_index_valid)
   );

endmodule

[hw/rtl/rbqp_checker.sv]
// Port-level checker for the profiler top level, with its bind statement.
// Uses rbqp_pkg.
`timescale 1ns / 1ps

module rbqp_checker import rbqp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [15:0] rsp_read_length,
   input logic [6:0]  rsp_gc_percent_bin,
   input logic [6:0]  rsp_mean_quality_bin,
   input logic        rsp_position_overflow,
   input logic [63:0] rsp_stat_value,
   input logic        rsp_index_valid
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("response or ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stat_value)
                                 && $stable(rsp_result_kind))
      else $error("stalled response changed");

   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SUMMARY |->
         rsp_stat_value == 64'd0 && !rsp_index_valid && rsp_read_length != 16'd0
         && rsp_gc_percent_bin <= 7'd100)
      else $error("malformed read summary");

   a_stat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_STAT |->
         rsp_read_length == 16'd0 && rsp_gc_percent_bin == 7'd0
         && rsp_mean_quality_bin == 7'd0 && !rsp_position_overflow
         && (rsp_index_valid || rsp_stat_value == 64'd0))
      else $error("malformed statistic response");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

endmodule

bind read_base_quality_profiler_top rbqp_checker u_rbqp_checker (.*);
